// File: rtl/core/phd_pkg.sv
// ----------------------------------------------------------------------------
// phd_pkg
// Shared types, character codes and the hex digit helper of the pipe hex escape decoder.
// ----------------------------------------------------------------------------
package phd_pkg;

	// character codes
	localparam logic [7:0] CH_PIPE   = 8'h7C;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_UP_A   = 8'h41;
	localparam logic [7:0] CH_UP_F   = 8'h46;
	localparam logic [7:0] CH_LOW_A  = 8'h61;
	localparam logic [7:0] CH_LOW_F  = 8'h66;
	localparam logic [3:0] ALPHA_ADJ = 4'd9;

	typedef enum logic [1:0] {
		MODE_LIT = 2'd0,
		MODE_HI  = 2'd1,
		MODE_LO  = 2'd2,
		MODE_SEP = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_SPACE = 2'd1,
		ST_BAD_HEX   = 2'd2,
		ST_TRUNC     = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_valid;
		logic       out_done;
		status_t    out_status;
	} result_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	// hex digit check and value
	function automatic hex_t hex_decode(input logic [7:0] b);
		hex_t h;
		h.ok  = 1'b0;
		h.val = 4'd0;
		if (b >= CH_ZERO && b <= CH_NINE) begin
			h.ok  = 1'b1;
			h.val = b[3:0];
		end else if ((b >= CH_UP_A && b <= CH_UP_F) || (b >= CH_LOW_A && b <= CH_LOW_F)) begin
			h.ok  = 1'b1;
			h.val = b[3:0] + ALPHA_ADJ;
		end
		return h;
	endfunction

endpackage

// File: rtl/core/phd_in_if.sv
// ----------------------------------------------------------------------------
// phd_in_if
// Input channel: one character of the content string per item.
// ----------------------------------------------------------------------------
interface phd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// File: rtl/core/phd_out_if.sv
// ----------------------------------------------------------------------------
// phd_out_if
// Output channel: one decode result per input item.
// ----------------------------------------------------------------------------
interface phd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_valid;
	logic       out_done;
	logic [1:0] out_status;

	modport source (output valid, output out_byte, output out_valid, output out_done,
		output out_status, input ready);
	modport sink   (input valid, input out_byte, input out_valid, input out_done,
		input out_status, output ready);
endinterface

// File: rtl/core/pipe_hex_escape_decoder.sv
// ----------------------------------------------------------------------------
// pipe_hex_escape_decoder
// Decodes pipe-delimited hex runs in a byte stream, one result per byte.
// ----------------------------------------------------------------------------
// Each input item is one character of a content string; in_last marks its end.
// Every item gives exactly one result item through the input register, then the
// result register. While the sink does not stall, a new item is taken every
// cycle: the rate is one item per clock, set by the mode register, which is
// updated as each item leaves the input register. Outside pipes a byte passes
// through with out_valid set. Between pipes, pairs of hex digits become one byte
// each, with a separator or a closing pipe after every pair. out_status carries
// the sticky error of the string: bad space for a space in a digit position,
// bad_hex for a non-hex digit, truncated when the string ends where a pair is due
// or half done. After an error no byte has out_valid set until the last byte; the
// decoder returns to its reset state after every last byte. din.ready depends on
// dout.ready combinationally when both registers hold items.
// ----------------------------------------------------------------------------
module pipe_hex_escape_decoder
	import phd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	phd_in_if.sink    din,
	phd_out_if.source dout
);

	// handshake between the stages
	logic    valid_s1;
	item_t   item_s1;
	logic    adv;
	logic    s2_free;
	result_t res;

	// input register
	phd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.din      (din),
		.s2_free  (s2_free),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.adv      (adv)
	);

	// mode machine and pair assembly
	phd_decode u_dec (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_s1),
		.adv    (adv),
		.res    (res)
	);

	// result register toward the sink
	phd_out_stage u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.res     (res),
		.adv     (adv),
		.s2_free (s2_free),
		.dout    (dout)
	);

endmodule

// File: rtl/core/phd_in_stage.sv
// ----------------------------------------------------------------------------
// phd_in_stage
// Input register of the decoder.
// ----------------------------------------------------------------------------
module phd_in_stage
	import phd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	phd_in_if.sink       din,
	input  logic         s2_free,
	output logic         valid_s1,
	output item_t        item_s1,
	output logic         adv
);

	assign adv       = valid_s1 && s2_free;
	assign din.ready = !valid_s1 || s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (din.ready) begin
			valid_s1 <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (din.ready && din.valid) begin
			item_s1.in_byte <= din.in_byte;
			item_s1.in_last <= din.in_last;
		end
	end

endmodule

// File: rtl/core/phd_decode.sv
// ----------------------------------------------------------------------------
// phd_decode
// Mode machine: decides one character per cycle while adv is high and keeps the string state.
// ----------------------------------------------------------------------------
module phd_decode
	import phd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  item_t   item,
	input  logic    adv,
	output result_t res
);

	mode_t      mode_q, mode_d;
	logic [3:0] nib_q, nib_d;
	logic       pend_q, pend_d;
	status_t    err_q, err_d;
	hex_t       hv;
	logic [7:0] obyte;
	logic       ovalid;

	always_comb begin
		mode_d = mode_q;
		nib_d  = nib_q;
		pend_d = pend_q;
		err_d  = err_q;
		obyte  = 8'd0;
		ovalid = 1'b0;
		hv     = hex_decode(item.in_byte);
		if (err_q == ST_OK) begin
			unique case (mode_q)
				MODE_LIT: begin
					if (item.in_byte == CH_PIPE) begin
						mode_d = MODE_HI;
					end else begin
						obyte  = item.in_byte;
						ovalid = 1'b1;
					end
				end
				MODE_HI: begin
					if (item.in_byte == CH_SPACE) begin
						err_d = ST_BAD_SPACE;
					end else begin
						// non-hex high digit waits for the low digit's space check
						nib_d  = hv.ok ? hv.val : 4'd0;
						pend_d = !hv.ok;
						mode_d = MODE_LO;
					end
				end
				MODE_LO: begin
					priority if (item.in_byte == CH_SPACE) begin
						err_d = ST_BAD_SPACE;
					end else if (pend_q || !hv.ok) begin
						err_d = ST_BAD_HEX;
					end else begin
						obyte  = {nib_q, hv.val};
						ovalid = 1'b1;
						mode_d = MODE_SEP;
					end
				end
				MODE_SEP: begin
					mode_d = (item.in_byte == CH_PIPE) ? MODE_LIT : MODE_HI;
				end
			endcase
			// string ends where a pair is due or half done
			if (item.in_last && err_d == ST_OK) begin
				if (mode_d == MODE_HI) begin
					err_d = ST_TRUNC;
				end else if (mode_d == MODE_LO) begin
					err_d = pend_d ? ST_BAD_HEX : ST_TRUNC;
				end
			end
		end
		res.out_byte   = obyte;
		res.out_valid  = ovalid;
		res.out_done   = item.in_last;
		res.out_status = err_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_LIT;
			nib_q  <= 4'd0;
			pend_q <= 1'b0;
			err_q  <= ST_OK;
		end else if (adv) begin
			if (item.in_last) begin
				mode_q <= MODE_LIT;
				nib_q  <= 4'd0;
				pend_q <= 1'b0;
				err_q  <= ST_OK;
			end else begin
				mode_q <= mode_d;
				nib_q  <= nib_d;
				pend_q <= pend_d;
				err_q  <= err_d;
			end
		end
	end

	a_reset_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		adv && item.in_last |=> mode_q == MODE_LIT && err_q == ST_OK && !pend_q)
		else $error("state not cleared after last item");

	a_silent_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		adv && err_q != ST_OK |-> !res.out_valid && res.out_status == err_q)
		else $error("output after sticky error");

endmodule

// File: rtl/core/phd_out_stage.sv
// ----------------------------------------------------------------------------
// phd_out_stage
// Result register: holds one decode result until the sink takes it.
// ----------------------------------------------------------------------------
module phd_out_stage
	import phd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  result_t  res,
	input  logic     adv,
	output logic     s2_free,
	phd_out_if.source dout
);

	logic    valid_s2;
	result_t res_s2;

	assign s2_free = !valid_s2 || dout.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= adv;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && s2_free) begin
			res_s2 <= res;
		end
	end

	assign dout.valid      = valid_s2;
	assign dout.out_byte   = res_s2.out_byte;
	assign dout.out_valid  = res_s2.out_valid;
	assign dout.out_done   = res_s2.out_done;
	assign dout.out_status = res_s2.out_status;

	a_byte_only_when_ok: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.out_valid |-> res_s2.out_status == ST_OK)
		else $error("decoded byte with error status");

	a_zero_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !res_s2.out_valid |-> res_s2.out_byte == 8'd0)
		else $error("nonzero byte without out_valid");

endmodule

// File: tb/pipe_hex_escape_decoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pipe_hex_escape_decoder_tb
// Self-checking bench for the pipe hex escape decoder. Content strings go in
// one character per item with random gaps and output stalls. A scoreboard
// runs its own decode of every accepted item and checks each result item
// field by field, in order. A short directed set covers byte extremes and
// each error and end-of-string case. Random strings follow, mostly literal
// stretches and well-formed hex runs, with some corrupted or cut short.
// ----------------------------------------------------------------------------
module pipe_hex_escape_decoder_tb
	import phd_pkg::*;
();

	localparam int CLK_LIMIT    = 200000;
	localparam int RANDOM_ITEMS = 1600;
	localparam int IDLE_PCT     = 22;
	localparam int TAIL_CYCLES  = 10;

	// own decode of the string, one expected result per accepted item
	class hex_run_scoreboard;
		mode_t      mode;
		logic [3:0] hi_nib;
		bit         hi_bad;
		status_t    err;
		result_t    expected[$];
		int         errors;

		function new();
			errors = 0;
			restart();
		endfunction

		function void restart();
			mode   = MODE_LIT;
			hi_nib = 4'd0;
			hi_bad = 1'b0;
			err    = ST_OK;
		endfunction

		function bit digit_value(input logic [7:0] b, output logic [3:0] v);
			logic [7:0] d;
			d = 8'd0;
			digit_value = 1'b1;
			if (b >= CH_ZERO && b <= CH_NINE) d = b - CH_ZERO;
			else if (b >= CH_UP_A && b <= CH_UP_F) d = b - CH_UP_A + 8'd10;
			else if (b >= CH_LOW_A && b <= CH_LOW_F) d = b - CH_LOW_A + 8'd10;
			else digit_value = 1'b0;
			v = d[3:0];
		endfunction

		function void note_item(input logic [7:0] b, input bit last);
			result_t    r;
			logic [3:0] v;
			r = '0;
			if (err == ST_OK) begin
				case (mode)
					MODE_LIT: begin
						if (b == CH_PIPE) mode = MODE_HI;
						else begin
							r.out_byte  = b;
							r.out_valid = 1'b1;
						end
					end
					MODE_HI: begin
						if (b == CH_SPACE) err = ST_BAD_SPACE;
						else begin
							// a non-hex high digit waits for the low digit
							hi_bad = !digit_value(b, v);
							hi_nib = hi_bad ? 4'd0 : v;
							mode   = MODE_LO;
						end
					end
					MODE_LO: begin
						if (b == CH_SPACE) err = ST_BAD_SPACE;
						else if (hi_bad || !digit_value(b, v)) err = ST_BAD_HEX;
						else begin
							r.out_byte  = {hi_nib, v};
							r.out_valid = 1'b1;
							mode        = MODE_SEP;
						end
					end
					default: mode = (b == CH_PIPE) ? MODE_LIT : MODE_HI;
				endcase
				// string ends where a pair is due or half done
				if (last && err == ST_OK) begin
					if (mode == MODE_HI) err = ST_TRUNC;
					else if (mode == MODE_LO) err = hi_bad ? ST_BAD_HEX : ST_TRUNC;
				end
			end
			r.out_done   = last;
			r.out_status = err;
			expected.push_back(r);
			if (last) restart();
		endfunction

		function void report(input string field, input int exp_val, input int got_val);
			$display("%0t: mismatch on %s: expected 0x%0h, actual 0x%0h",
				$time, field, exp_val, got_val);
			errors++;
		endfunction

		function void check_result(input result_t got);
			result_t e;
			if (expected.size() == 0) begin
				$display("%0t: result item with nothing expected: expected none, actual %p",
					$time, got);
				errors++;
				return;
			end
			e = expected.pop_front();
			if (got.out_byte !== e.out_byte) report("out_byte", e.out_byte, got.out_byte);
			if (got.out_valid !== e.out_valid) report("out_valid", e.out_valid, got.out_valid);
			if (got.out_done !== e.out_done) report("out_done", e.out_done, got.out_done);
			if (got.out_status !== e.out_status)
				report("out_status", e.out_status, got.out_status);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   quiet;        // no idling on either side while set
	int   items_sent;
	int   cycles;

	hex_run_scoreboard sb = new();

	phd_in_if  din_if ();
	phd_out_if dout_if ();

	pipe_hex_escape_decoder u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_if),
		.dout   (dout_if)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// run limit
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CLK_LIMIT) begin
				$display("pipe_hex_escape_decoder_tb: errors");
				$finish;
			end
		end
	end

	// result side: sample at the rising edge, stall at random from the falling one
	initial begin
		dout_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && dout_if.valid && dout_if.ready)
				sb.check_result({dout_if.out_byte, dout_if.out_valid, dout_if.out_done,
					status_t'(dout_if.out_status)});
			@(negedge clk);
			dout_if.ready = quiet || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// one item: random gap, then hold until the handshake; called and left at a falling edge
	task automatic send_item(input logic [7:0] b, input bit last);
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			din_if.valid = 1'b0;
			@(negedge clk);
		end
		din_if.valid   = 1'b1;
		din_if.in_byte = b;
		din_if.in_last = last;
		do @(posedge clk); while (!din_if.ready);
		sb.note_item(b, last);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_text(input string s, input bit ends);
		for (int i = 0; i < s.len(); i++)
			send_item(s[i], ends && (i == s.len() - 1));
	endtask

	// sender holds off until every result item is back
	task automatic wait_for_drain();
		din_if.valid = 1'b0;
		while (sb.expected.size() != 0) @(negedge clk);
	endtask

	function automatic logic [7:0] rand_digit();
		case ($urandom_range(2))
			0: return CH_ZERO + 8'($urandom_range(9));
			1: return CH_UP_A + 8'($urandom_range(5));
			default: return CH_LOW_A + 8'($urandom_range(5));
		endcase
	endfunction

	// one random string: literal stretches and hex runs, sometimes broken
	task automatic send_random_string();
		logic [7:0] q[$];
		logic [7:0] b;
		int         n;
		int         pos;
		q = {};
		repeat ($urandom_range(1, 4)) begin
			if ($urandom_range(1)) begin
				// literal bytes, any value; a stray pipe just opens a run
				repeat ($urandom_range(0, 4)) q.push_back(8'($urandom_range(255)));
			end else begin
				n = $urandom_range(1, 3);
				q.push_back(CH_PIPE);
				for (int p = 0; p < n; p++) begin
					q.push_back(rand_digit());
					q.push_back(rand_digit());
					if (p != n - 1) begin
						do b = 8'($urandom_range(255)); while (b == CH_PIPE);
						q.push_back(b);
					end
				end
				// some runs are left open at the end
				if ($urandom_range(5) != 0) q.push_back(CH_PIPE);
			end
		end
		if (q.size() == 0) q.push_back(8'($urandom_range(255)));
		// corrupt one position
		if ($urandom_range(99) < 20) begin
			pos = $urandom_range(q.size() - 1);
			case ($urandom_range(2))
				0: q[pos] = CH_SPACE;
				1: q[pos] = CH_PIPE;
				default: q[pos] = 8'($urandom_range(255));
			endcase
		end
		// cut short
		if ($urandom_range(99) < 10) begin
			pos = $urandom_range(1, q.size());
			while (q.size() > pos) void'(q.pop_back());
		end
		foreach (q[i]) send_item(q[i], i == q.size() - 1);
	endtask

	initial begin
		bit drained;
		arst_n         = 1'b0;
		din_if.valid   = 1'b0;
		din_if.in_byte = 8'd0;
		din_if.in_last = 1'b0;
		quiet          = 1'b0;
		items_sent     = 0;
		drained        = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// byte extremes as literals and as a decoded pair, space separator, closed run
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b0);
		send_text("|00 fF|", 1'b1);
		// space in the high digit, then sticky error
		send_text("| x", 1'b1);
		// non-hex high digit then space: bad space wins
		send_text("|g ", 1'b1);
		// non-hex low digit
		send_text("|1g", 1'b1);
		// ends on a non-hex high digit: bad hex, not truncated
		send_text("|g", 1'b1);
		// ends right after the opening pipe
		send_text("|", 1'b1);
		// ends on a comma in the low digit position: bad hex
		send_text("|1,", 1'b1);
		// ends after a hex high digit
		send_text("|a", 1'b1);
		wait_for_drain();

		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			quiet = (items_sent >= 700 && items_sent < 1000);
			if (!drained && items_sent >= 1200) begin
				wait_for_drain();
				drained = 1'b1;
			end
			send_random_string();
		end
		quiet = 1'b0;
		wait_for_drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (sb.expected.size() != 0) begin
			$display("%0t: result items missing: expected %0d more, actual 0",
				$time, sb.expected.size());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("pipe_hex_escape_decoder_tb: clean");
		else
			$display("pipe_hex_escape_decoder_tb: errors");
		$finish;
	end

endmodule
